[rtl/qspd_pkg.sv]
package qspd_pkg;

    // Widths of the fixed fields.
    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned COUNT_W = 6;
    localparam int unsigned STAT_W  = 2;

    // Default pair cap, the reset value of the pair limit and the queue depth.
    localparam int unsigned MAX_PAIRS_DEF   = 32;
    localparam int unsigned QUEUE_DEPTH_DEF = 4;
    localparam logic [COUNT_W-1:0] PAIR_LIMIT_RESET = 6'd32;

    // Status codes carried with every result.
    localparam logic [STAT_W-1:0] ST_OK         = 2'd0;
    localparam logic [STAT_W-1:0] ST_BAD_ESCAPE = 2'd1;
    localparam logic [STAT_W-1:0] ST_TOO_MANY   = 2'd2;

    // Progress through a percent escape.
    localparam logic [1:0] ESC_NONE   = 2'd0;
    localparam logic [1:0] ESC_FIRST  = 2'd1;
    localparam logic [1:0] ESC_SECOND = 2'd2;

    // Characters with a meaning in the query syntax.
    localparam logic [BYTE_W-1:0] CH_PLUS    = 8'h2B;
    localparam logic [BYTE_W-1:0] CH_PERCENT = 8'h25;
    localparam logic [BYTE_W-1:0] CH_SPACE   = 8'h20;
    localparam logic [BYTE_W-1:0] CH_AMP     = 8'h26;
    localparam logic [BYTE_W-1:0] CH_EQUALS  = 8'h3D;

    // One decoded result as it travels through the queue.
    typedef struct packed {
        logic [BYTE_W-1:0]  out_byte;
        logic               byte_valid;
        logic               in_value;
        logic               pair_done;
        logic               stream_done;
        logic [STAT_W-1:0]  status;
        logic [COUNT_W-1:0] pair_total;
    } t_result;

    localparam int unsigned RESULT_W = $bits(t_result);

    // Hex digit decode: bit 4 says the character is a digit, bits 3:0 hold its value.
    function automatic logic [4:0] hex_decode(input logic [BYTE_W-1:0] c);
        logic [BYTE_W-1:0] d;
        logic [4:0]        r;
        d = '0;
        r = '0;
        if (c >= 8'h30 && c <= 8'h39) begin
            d = c - 8'h30;
            r = {1'b1, d[3:0]};
        end else if (c >= 8'h61 && c <= 8'h66) begin
            d = c - 8'h57;
            r = {1'b1, d[3:0]};
        end else if (c >= 8'h41 && c <= 8'h46) begin
            d = c - 8'h37;
            r = {1'b1, d[3:0]};
        end
        return r;
    endfunction

endpackage

[rtl/qspd_fifo.sv]
module qspd_fifo #(
    parameter int unsigned WIDTH = 20,
    parameter int unsigned DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_rdata,
    output logic             o_full,
    output logic             o_empty
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count,  n_count;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_rdata = r_mem[r_rd_ptr];

    // Pointer and fill count updates.
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Storage needs no reset.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_wdata;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (!o_full || i_pop))
        else $error("queue written while full");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_empty)
        else $error("queue read while empty");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && !i_pop) |=> (r_count == $past(r_count) + 1'b1))
        else $error("fill count did not follow a write");

endmodule

[rtl/qspd_front.sv]
module qspd_front #(
    parameter int unsigned MAX_PAIRS = qspd_pkg::MAX_PAIRS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_s_tvalid,
    input  logic                             i_ready,
    input  logic [qspd_pkg::BYTE_W-1:0]      i_s_tdata,
    input  logic                             i_s_tlast,
    input  logic                             i_s_tuser,
    input  logic                             i_cfg_we,
    input  logic [qspd_pkg::COUNT_W-1:0]     i_cfg_wdata,
    output logic                             o_push,
    output qspd_pkg::t_result                o_res
);

    import qspd_pkg::*;

    localparam logic [COUNT_W-1:0] LIMIT_CAP = COUNT_W'(MAX_PAIRS);

    // Per-string decoder state and the pair limit register.
    logic               r_phase,  n_phase;
    logic [1:0]         r_esc,    n_esc;
    logic [3:0]         r_hn,     n_hn;
    logic [COUNT_W-1:0] r_ps,     n_ps;
    logic               r_failed, n_failed;
    logic               r_open,   n_open;
    logic [COUNT_W-1:0] r_pair_limit;

    logic               accept;
    logic [COUNT_W-1:0] limit_now;
    logic [4:0]         hex;
    logic               err;
    logic [STAT_W-1:0]  err_code;
    logic               pdone;
    logic               bvalid;
    logic [BYTE_W-1:0]  obyte;
    logic               res_push;

    assign accept    = i_s_tvalid && i_ready;
    assign limit_now = (r_pair_limit > LIMIT_CAP) ? LIMIT_CAP : r_pair_limit;
    assign hex       = hex_decode(i_s_tdata);
    assign o_push    = accept && res_push;

    // Classify the beat and work out the next state and the result, if any.
    always_comb begin
        n_phase  = r_phase;
        n_esc    = r_esc;
        n_hn     = r_hn;
        n_ps     = r_ps;
        n_failed = r_failed;
        n_open   = r_open;
        err      = 1'b0;
        err_code = ST_OK;
        pdone    = 1'b0;
        bvalid   = 1'b0;
        obyte    = '0;
        res_push = 1'b0;
        o_res    = '0;

        if (r_failed) begin
            // Drop everything until the end of the string.
            if (i_s_tlast) begin
                n_failed = 1'b0;
                n_phase  = 1'b0;
                n_esc    = ESC_NONE;
                n_hn     = '0;
                n_ps     = '0;
                n_open   = 1'b0;
            end
        end else if (!(i_s_tuser && !i_s_tlast)) begin
            if (!i_s_tuser) begin
                if (!r_open && (r_ps >= limit_now)) begin
                    err      = 1'b1;
                    err_code = ST_TOO_MANY;
                end else begin
                    n_open = 1'b1;
                    if (i_s_tdata == CH_AMP) begin
                        if (r_esc != ESC_NONE) begin
                            err      = 1'b1;
                            err_code = ST_BAD_ESCAPE;
                        end else begin
                            n_ps    = r_ps + 1'b1;
                            n_open  = 1'b0;
                            n_phase = 1'b0;
                            pdone   = 1'b1;
                        end
                    end else if (r_esc != ESC_NONE) begin
                        if (!hex[4]) begin
                            err      = 1'b1;
                            err_code = ST_BAD_ESCAPE;
                        end else if (r_esc == ESC_FIRST) begin
                            n_hn  = hex[3:0];
                            n_esc = ESC_SECOND;
                        end else begin
                            obyte  = {r_hn, hex[3:0]};
                            bvalid = 1'b1;
                            n_esc  = ESC_NONE;
                        end
                    end else if (i_s_tdata == CH_EQUALS && !r_phase) begin
                        n_phase = 1'b1;
                    end else if (i_s_tdata == CH_PLUS) begin
                        obyte  = CH_SPACE;
                        bvalid = 1'b1;
                    end else if (i_s_tdata == CH_PERCENT) begin
                        n_esc = ESC_FIRST;
                    end else begin
                        obyte  = i_s_tdata;
                        bvalid = 1'b1;
                    end
                end
            end

            // The end of the string closes an open pair or exposes a cut-off escape.
            if (!err && i_s_tlast) begin
                if (n_esc != ESC_NONE) begin
                    err      = 1'b1;
                    err_code = ST_BAD_ESCAPE;
                end else if (n_open) begin
                    n_ps  = n_ps + 1'b1;
                    pdone = 1'b1;
                end
            end

            if (err) begin
                res_push          = 1'b1;
                o_res.stream_done = 1'b1;
                o_res.status      = err_code;
                o_res.pair_total  = r_ps;
                n_failed          = !i_s_tlast;
            end else begin
                res_push          = bvalid || pdone || i_s_tlast;
                o_res.out_byte    = obyte;
                o_res.byte_valid  = bvalid;
                o_res.in_value    = bvalid && r_phase;
                o_res.pair_done   = pdone;
                o_res.stream_done = i_s_tlast;
                o_res.status      = ST_OK;
                o_res.pair_total  = n_ps;
            end

            // Every string starts afresh after its last beat.
            if (i_s_tlast) begin
                n_failed = 1'b0;
                n_phase  = 1'b0;
                n_esc    = ESC_NONE;
                n_hn     = '0;
                n_ps     = '0;
                n_open   = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= 1'b0;
            r_esc        <= ESC_NONE;
            r_hn         <= '0;
            r_ps         <= '0;
            r_failed     <= 1'b0;
            r_open       <= 1'b0;
            r_pair_limit <= PAIR_LIMIT_RESET;
        end else begin
            if (accept) begin
                r_phase  <= n_phase;
                r_esc    <= n_esc;
                r_hn     <= n_hn;
                r_ps     <= n_ps;
                r_failed <= n_failed;
                r_open   <= n_open;
            end
            if (i_cfg_we) begin
                r_pair_limit <= i_cfg_wdata;
            end
        end
    end

    a_failed_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_failed |-> !o_push)
        else $error("result produced while dropping a failed string");

    a_error_latches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_push && o_res.status != ST_OK && !i_s_tlast) |=> r_failed)
        else $error("error report did not enter the failed state");

    a_last_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_s_tlast) |=> (r_ps == '0 && !r_open && !r_failed && r_esc == ESC_NONE))
        else $error("string state not cleared after the last beat");

endmodule

[rtl/qspd_back.sv]
module qspd_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  qspd_pkg::t_result i_res,
    input  logic              i_empty,
    output logic              o_pop,
    output logic              o_m_tvalid,
    input  logic              i_m_tready,
    output logic [23:0]       o_m_tdata,  // out_byte[7:0], pair_done[8], status[10:9],
                                          // pair_total[16:11], zero[23:17]
    output logic              o_m_tlast,  // stream_done
    output logic [1:0]        o_m_tuser   // byte_valid[0], in_value[1]
);

    import qspd_pkg::*;

    logic    r_valid;
    t_result r_res;

    // Refill the output register whenever it is empty or being drained.
    assign o_pop = !i_empty && (!r_valid || i_m_tready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_res <= i_res;
        end
    end

    // Pack the result onto the master-side beat.
    assign o_m_tvalid = r_valid;
    assign o_m_tdata  = {7'd0, r_res.pair_total, r_res.status, r_res.pair_done, r_res.out_byte};
    assign o_m_tlast  = r_res.stream_done;
    assign o_m_tuser  = {r_res.in_value, r_res.byte_valid};

    a_hold_unless_taken: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && !i_m_tready) |-> !o_pop)
        else $error("output register overwritten while stalled");

    a_refill_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |=> r_valid)
        else $error("output register not valid after a refill");

    a_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && i_m_tready && i_empty) |=> !r_valid)
        else $error("output beat repeated after it was taken");

endmodule

[rtl/query_string_pair_decoder.sv]
// Query string pair decoder.
// Slave side: one raw byte of a URL-encoded query string per beat in
// s_tdata; s_tlast marks the final beat of the string and s_tuser set means
// the beat carries no byte (only useful together with s_tlast, to end a
// string without a further byte). Master side: at most one result per input
// beat, carrying the decoded byte with its name/value tag, pair completion,
// end of string, status and the running pair count.
// The pair limit is to be written through i_cfg_we/i_cfg_wdata only while
// the block is idle; the block itself does not enforce this. Values above
// MAX_PAIRS act as MAX_PAIRS. Throughput is one beat per cycle while the
// queue is not full: the front classifies a beat in the cycle it is
// accepted and writes its result into a small queue, and the back moves
// queue entries into the output register whenever that register is empty
// or being drained. A stalled receiver fills the queue; s_tready falls only
// once the queue is full.
// Reset clears the string state, empties the queue and the output register,
// and sets the pair limit to 32.
module query_string_pair_decoder #(
    parameter int unsigned MAX_PAIRS   = qspd_pkg::MAX_PAIRS_DEF,
    parameter int unsigned QUEUE_DEPTH = qspd_pkg::QUEUE_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // in_byte[7:0]
    input  logic        i_s_tlast,   // is_last
    input  logic        i_s_tuser,   // no_byte
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [23:0] o_m_tdata,   // out_byte[7:0], pair_done[8], status[10:9],
                                     // pair_total[16:11], zero[23:17]
    output logic        o_m_tlast,   // stream_done
    output logic [1:0]  o_m_tuser,   // byte_valid[0], in_value[1]
    input  logic        i_cfg_we,
    input  logic [5:0]  i_cfg_wdata  // pair_limit
);

    import qspd_pkg::*;

    logic                push;
    logic                pop;
    logic                full;
    logic                empty;
    t_result             front_res;
    t_result             back_res;
    logic [RESULT_W-1:0] q_rdata;

    assign o_s_tready = !full;
    assign back_res   = t_result'(q_rdata);

    qspd_front #(
        .MAX_PAIRS (MAX_PAIRS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .i_ready     (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tlast   (i_s_tlast),
        .i_s_tuser   (i_s_tuser),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .o_push      (push),
        .o_res       (front_res)
    );

    qspd_fifo #(
        .WIDTH (RESULT_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_wdata (front_res),
        .i_pop   (pop),
        .o_rdata (q_rdata),
        .o_full  (full),
        .o_empty (empty)
    );

    qspd_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_res      (back_res),
        .i_empty    (empty),
        .o_pop      (pop),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast),
        .o_m_tuser  (o_m_tuser)
    );

endmodule

[test/tb_query_string_pair_decoder.sv]
module tb_query_string_pair_decoder;
    timeunit 1ns;
    timeprecision 1ps;

    import qspd_pkg::*;

    // One raw beat of a query string as it is offered on the slave side.
    typedef struct packed {
        logic [7:0] b;
        logic       last;
        logic       nob;
    } query_beat_t;

    typedef enum {ROW_BEAT, ROW_LIMIT} row_kind_e;

    // One row of the directed stimulus; typed rows carry their own expected result.
    typedef struct {
        row_kind_e   kind;
        query_beat_t beat;
        bit          typed;
        bit          has_res;
        t_result     res;
        logic [5:0]  limit;
    } stim_row_t;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_s_tvalid = 1'b0;
    logic        o_s_tready;
    logic [7:0]  i_s_tdata = '0;    // in_byte[7:0]
    logic        i_s_tlast = 1'b0;  // is_last
    logic        i_s_tuser = 1'b0;  // no_byte
    logic        o_m_tvalid;
    logic        i_m_tready = 1'b0;
    logic [23:0] o_m_tdata;         // out_byte[7:0], pair_done[8], status[10:9],
                                    // pair_total[16:11], zero[23:17]
    logic        o_m_tlast;         // stream_done
    logic [1:0]  o_m_tuser;         // byte_valid[0], in_value[1]
    logic        i_cfg_we = 1'b0;
    logic [5:0]  i_cfg_wdata = '0;  // pair_limit

    query_string_pair_decoder dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tlast   (i_s_tlast),
        .i_s_tuser   (i_s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tlast   (o_m_tlast),
        .o_m_tuser   (o_m_tuser),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    // Decoder state mirrored by the predictor.
    logic [5:0] limit_reg = PAIR_LIMIT_RESET;
    logic       val_part = 1'b0;
    logic [1:0] esc_stage = ESC_NONE;
    logic [3:0] hi_nib = '0;
    logic [5:0] pair_cnt = '0;
    logic       broken = 1'b0;
    logic       pair_started = 1'b0;

    t_result     decoded_q[$];
    query_beat_t query_beats[$];
    stim_row_t   directed_rows[$];
    int          fail_count = 0;
    bit          tx_idle_on = 1'b1;
    bit          rx_idle_on = 1'b1;
    bit          hold_armed = 1'b0;
    int          hold_left = 0;

    // Clock generation.
    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // Overall time limit.
    initial begin
        #2000000;
        $display("Verification failed");
        $finish;
    end

    function automatic void clear_decoder();
        val_part = 1'b0;
        esc_stage = ESC_NONE;
        hi_nib = '0;
        pair_cnt = '0;
        broken = 1'b0;
        pair_started = 1'b0;
    endfunction

    function automatic int hex_digit(logic [7:0] c);
        if (c >= "0" && c <= "9") return int'(c - "0");
        if (c >= "a" && c <= "f") return int'(c - "a") + 10;
        if (c >= "A" && c <= "F") return int'(c - "A") + 10;
        return -1;
    endfunction

    function automatic bit raise_error(logic [1:0] code, bit last, output t_result r);
        r = '0;
        r.stream_done = 1'b1;
        r.status = code;
        r.pair_total = pair_cnt;
        if (last) begin
            clear_decoder();
        end else begin
            broken = 1'b1;
        end
        return 1'b1;
    endfunction

    // Predicts the result, if any, caused by one accepted beat.
    function automatic bit decode_beat(query_beat_t bt, output t_result r);
        int         digit;
        logic [5:0] eff_limit;
        r = '0;
        eff_limit = (limit_reg > MAX_PAIRS_DEF) ? 6'(MAX_PAIRS_DEF) : limit_reg;
        if (broken) begin
            if (bt.last) clear_decoder();
            return 1'b0;
        end
        if (bt.nob && !bt.last) return 1'b0;
        if (!bt.nob) begin
            if (!pair_started) begin
                if (pair_cnt >= eff_limit) return raise_error(ST_TOO_MANY, bt.last, r);
                pair_started = 1'b1;
            end
            if (bt.b == CH_AMP) begin
                if (esc_stage != ESC_NONE) return raise_error(ST_BAD_ESCAPE, bt.last, r);
                pair_cnt = pair_cnt + 6'd1;
                pair_started = 1'b0;
                val_part = 1'b0;
                r.pair_done = 1'b1;
            end else if (esc_stage != ESC_NONE) begin
                digit = hex_digit(bt.b);
                if (digit < 0) return raise_error(ST_BAD_ESCAPE, bt.last, r);
                if (esc_stage == ESC_FIRST) begin
                    hi_nib = 4'(digit);
                    esc_stage = ESC_SECOND;
                end else begin
                    r.out_byte = {hi_nib, 4'(digit)};
                    r.byte_valid = 1'b1;
                    r.in_value = val_part;
                    esc_stage = ESC_NONE;
                end
            end else if (bt.b == CH_EQUALS && !val_part) begin
                val_part = 1'b1;
            end else if (bt.b == CH_PLUS) begin
                r.out_byte = CH_SPACE;
                r.byte_valid = 1'b1;
                r.in_value = val_part;
            end else if (bt.b == CH_PERCENT) begin
                esc_stage = ESC_FIRST;
            end else begin
                r.out_byte = bt.b;
                r.byte_valid = 1'b1;
                r.in_value = val_part;
            end
        end
        if (bt.last) begin
            if (esc_stage != ESC_NONE) return raise_error(ST_BAD_ESCAPE, 1'b1, r);
            if (pair_started) begin
                pair_cnt = pair_cnt + 6'd1;
                r.pair_done = 1'b1;
            end
        end
        if (!r.byte_valid && !r.pair_done && !bt.last) return 1'b0;
        r.stream_done = bt.last;
        r.status = ST_OK;
        r.pair_total = pair_cnt;
        if (bt.last) clear_decoder();
        return 1'b1;
    endfunction

    // Offers one beat, waits for the handshake and records what it should cause.
    task automatic send_beat(query_beat_t bt, bit typed = 1'b0, bit typed_has = 1'b0,
                             t_result typed_res = '0);
        int      gaps;
        bit      has;
        t_result pred;
        gaps = 0;
        if (tx_idle_on) begin
            while ($urandom_range(99) < 15) gaps++;
        end
        if (gaps > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gaps) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata <= bt.b;
        i_s_tlast <= bt.last;
        i_s_tuser <= bt.nob;
        do @(posedge i_clk); while (!o_s_tready);
        has = decode_beat(bt, pred);
        if (typed) begin
            has = typed_has;
            pred = typed_res;
        end
        if (has) decoded_q.push_back(pred);
    endtask

    // The limit is only written once the decoder has drained.
    task automatic write_limit(logic [5:0] v);
        i_s_tvalid <= 1'b0;
        while (decoded_q.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        limit_reg = v;
        i_cfg_we <= 1'b0;
    endtask

    function automatic logic [7:0] hex_char(logic [3:0] v);
        if (v < 4'd10) return 8'("0") + 8'(v);
        return (($urandom_range(1) == 1) ? 8'("a") : 8'("A")) + 8'(v) - 8'd10;
    endfunction

    function automatic void push_byte(logic [7:0] b);
        query_beats.push_back('{b, 1'b0, 1'b0});
    endfunction

    // Appends n random tokens: literals, plus signs, escapes and raw noise bytes.
    function automatic void push_tokens(int n);
        logic [7:0] c;
        for (int k = 0; k < n; k++) begin
            case ($urandom_range(9))
                0: push_byte(CH_PLUS);
                1, 2: begin
                    c = 8'($urandom_range(255));
                    push_byte(CH_PERCENT);
                    push_byte(hex_char(c[7:4]));
                    push_byte(hex_char(c[3:0]));
                end
                3: push_byte(8'($urandom_range(255)));
                default: begin
                    do c = 8'($urandom_range(33, 126));
                    while (c == CH_AMP || c == CH_EQUALS || c == CH_PERCENT || c == CH_PLUS);
                    push_byte(c);
                end
            endcase
        end
    endfunction

    // Builds one query string: mostly well formed, some broken, some pure noise.
    task automatic compose_query();
        int         style;
        int         npairs;
        int         pos;
        logic [7:0] junk;
        query_beats.delete();
        style = $urandom_range(99);
        if (style < 8) begin
            repeat ($urandom_range(1, 12)) push_byte(8'($urandom_range(255)));
        end else begin
            npairs = ($urandom_range(19) == 0) ? $urandom_range(28, 40) : $urandom_range(0, 4);
            for (int p = 0; p < npairs; p++) begin
                if (p > 0) push_byte(CH_AMP);
                push_tokens($urandom_range(0, 3));
                if ($urandom_range(3) != 0) begin
                    push_byte(CH_EQUALS);
                    push_tokens($urandom_range(0, 4));
                end
            end
            if (npairs > 0 && $urandom_range(5) == 0) push_byte(CH_AMP);
            // Broken escapes: a bad digit somewhere, or an escape cut off at the end.
            if (style < 22) begin
                do junk = 8'($urandom_range(255)); while (hex_digit(junk) >= 0);
                pos = $urandom_range(query_beats.size());
                case ($urandom_range(2))
                    0: begin
                        query_beats.insert(pos, '{junk, 1'b0, 1'b0});
                        query_beats.insert(pos, '{CH_PERCENT, 1'b0, 1'b0});
                    end
                    1: begin
                        query_beats.insert(pos, '{junk, 1'b0, 1'b0});
                        query_beats.insert(pos, '{hex_char(4'($urandom)), 1'b0, 1'b0});
                        query_beats.insert(pos, '{CH_PERCENT, 1'b0, 1'b0});
                    end
                    default: begin
                        push_byte(CH_PERCENT);
                        if ($urandom_range(1) == 1) push_byte(hex_char(4'($urandom)));
                    end
                endcase
            end
        end
        // Beats without a byte that are not last are ignored by the decoder.
        if ($urandom_range(9) == 0) begin
            pos = $urandom_range(query_beats.size());
            query_beats.insert(pos, '{8'($urandom_range(255)), 1'b0, 1'b1});
        end
        if (query_beats.size() == 0 || $urandom_range(3) == 0) begin
            query_beats.push_back('{8'($urandom_range(255)), 1'b1, 1'b1});
        end else begin
            query_beats[$].last = 1'b1;
        end
    endtask

    // Receiver: random stalls, a quiet stretch, and one long hold-off on request.
    initial begin
        forever begin
            @(posedge i_clk);
            if (hold_left > 0) begin
                i_m_tready <= 1'b0;
                hold_left--;
            end else if (hold_armed) begin
                hold_armed = 1'b0;
                hold_left = 300;
                i_m_tready <= 1'b0;
            end else begin
                i_m_tready <= !(rx_idle_on && $urandom_range(99) < 15);
            end
        end
    end

    task automatic check_field(string fname, int unsigned want, int unsigned got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, fname, want, got);
            fail_count++;
        end
    endtask

    // Every result beat is compared with the oldest outstanding prediction.
    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            got = '0;
            got.out_byte = o_m_tdata[7:0];
            got.pair_done = o_m_tdata[8];
            got.status = o_m_tdata[10:9];
            got.pair_total = o_m_tdata[16:11];
            got.stream_done = o_m_tlast;
            got.byte_valid = o_m_tuser[0];
            got.in_value = o_m_tuser[1];
            if (decoded_q.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual %h", $time, got);
                fail_count++;
            end else begin
                want = decoded_q.pop_front();
                check_field("out_byte", want.out_byte, got.out_byte);
                check_field("byte_valid", want.byte_valid, got.byte_valid);
                check_field("in_value", want.in_value, got.in_value);
                check_field("pair_done", want.pair_done, got.pair_done);
                check_field("stream_done", want.stream_done, got.stream_done);
                check_field("status", want.status, got.status);
                check_field("pair_total", want.pair_total, got.pair_total);
            end
        end
    end

    function automatic stim_row_t plain_row(logic [7:0] b, bit last = 1'b0, bit nob = 1'b0);
        return '{ROW_BEAT, '{b, last, nob}, 1'b0, 1'b0, '0, '0};
    endfunction

    function automatic stim_row_t typed_row(logic [7:0] b, bit last, bit nob, bit has,
                                            t_result res);
        return '{ROW_BEAT, '{b, last, nob}, 1'b1, has, res, '0};
    endfunction

    function automatic stim_row_t limit_row(logic [5:0] v);
        return '{ROW_LIMIT, '0, 1'b0, 1'b0, '0, v};
    endfunction

    // Main sequence: reset, directed rows, then random phases under several limits.
    initial begin
        int          sent;
        logic [5:0]  lim;
        query_beat_t bt;
        int          phase_limit[9];

        phase_limit = '{32, 0, 1, 2, 5, 32, 33, 63, -1};

        // Empty string, ignored beat, plus sign, escapes at both extremes.
        directed_rows.push_back(typed_row(8'h00, 1'b1, 1'b1, 1'b1,
                                t_result'{8'h00, 1'b0, 1'b0, 1'b0, 1'b1, ST_OK, 6'd0}));
        directed_rows.push_back(typed_row(8'hFF, 1'b0, 1'b1, 1'b0, '0));
        directed_rows.push_back(typed_row("a", 1'b0, 1'b0, 1'b1,
                                t_result'{"a", 1'b1, 1'b0, 1'b0, 1'b0, ST_OK, 6'd0}));
        directed_rows.push_back(typed_row(CH_PLUS, 1'b0, 1'b0, 1'b1,
                                t_result'{CH_SPACE, 1'b1, 1'b0, 1'b0, 1'b0, ST_OK, 6'd0}));
        directed_rows.push_back(plain_row(CH_EQUALS));
        directed_rows.push_back(plain_row(CH_PERCENT));
        directed_rows.push_back(plain_row("f"));
        directed_rows.push_back(typed_row("F", 1'b0, 1'b0, 1'b1,
                                t_result'{8'hFF, 1'b1, 1'b1, 1'b0, 1'b0, ST_OK, 6'd0}));
        directed_rows.push_back(plain_row(CH_PERCENT));
        directed_rows.push_back(plain_row("0"));
        directed_rows.push_back(typed_row("0", 1'b0, 1'b0, 1'b1,
                                t_result'{8'h00, 1'b1, 1'b1, 1'b0, 1'b0, ST_OK, 6'd0}));
        // A second equals sign in the value is literal; two ampersands give an empty pair.
        directed_rows.push_back(plain_row(CH_EQUALS));
        directed_rows.push_back(plain_row(CH_AMP));
        directed_rows.push_back(plain_row(CH_AMP));
        // Bad second digit, then everything is dropped until the last beat.
        directed_rows.push_back(plain_row(CH_PERCENT));
        directed_rows.push_back(plain_row("A"));
        directed_rows.push_back(typed_row("g", 1'b0, 1'b0, 1'b1,
                                t_result'{8'h00, 1'b0, 1'b0, 1'b0, 1'b1, ST_BAD_ESCAPE, 6'd2}));
        directed_rows.push_back(typed_row("x", 1'b1, 1'b0, 1'b0, '0));
        // Escape still pending at an ampersand that is also the last beat.
        directed_rows.push_back(plain_row(CH_PERCENT));
        directed_rows.push_back(typed_row(CH_AMP, 1'b1, 1'b0, 1'b1,
                                t_result'{8'h00, 1'b0, 1'b0, 1'b0, 1'b1, ST_BAD_ESCAPE, 6'd0}));
        // Equals sign where a hex digit is due, on the last beat.
        directed_rows.push_back(plain_row(CH_PERCENT));
        directed_rows.push_back(typed_row(CH_EQUALS, 1'b1, 1'b0, 1'b1,
                                t_result'{8'h00, 1'b0, 1'b0, 1'b0, 1'b1, ST_BAD_ESCAPE, 6'd0}));
        // A limit of zero rejects the very first byte.
        directed_rows.push_back(limit_row(6'd0));
        directed_rows.push_back(typed_row("z", 1'b1, 1'b0, 1'b1,
                                t_result'{8'h00, 1'b0, 1'b0, 1'b0, 1'b1, ST_TOO_MANY, 6'd0}));
        // A limit of one rejects the second pair.
        directed_rows.push_back(limit_row(6'd1));
        directed_rows.push_back(plain_row("q"));
        directed_rows.push_back(plain_row(CH_AMP));
        directed_rows.push_back(typed_row("r", 1'b0, 1'b0, 1'b1,
                                t_result'{8'h00, 1'b0, 1'b0, 1'b0, 1'b1, ST_TOO_MANY, 6'd1}));
        directed_rows.push_back(typed_row(CH_AMP, 1'b1, 1'b0, 1'b0, '0));
        // Top of the register range; a trailing ampersand opens no new pair.
        directed_rows.push_back(limit_row(6'd63));
        directed_rows.push_back(plain_row("k"));
        directed_rows.push_back(typed_row(CH_AMP, 1'b1, 1'b0, 1'b1,
                                t_result'{8'h00, 1'b0, 1'b0, 1'b1, 1'b1, ST_OK, 6'd1}));

        clear_decoder();
        limit_reg = PAIR_LIMIT_RESET;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_rows[i]) begin
            if (directed_rows[i].kind == ROW_LIMIT) begin
                write_limit(directed_rows[i].limit);
            end else begin
                send_beat(directed_rows[i].beat, directed_rows[i].typed,
                          directed_rows[i].has_res, directed_rows[i].res);
            end
        end

        // Random phases; phase 3 holds the receiver off, phase 5 runs without idling.
        for (int ph = 0; ph < 9; ph++) begin
            lim = (phase_limit[ph] < 0) ? 6'($urandom_range(63)) : 6'(phase_limit[ph]);
            write_limit(lim);
            tx_idle_on = !(ph == 3 || ph == 5);
            rx_idle_on = (ph != 5);
            if (ph == 3) hold_armed = 1'b1;
            sent = 0;
            while (sent < 170) begin
                compose_query();
                foreach (query_beats[k]) begin
                    bt = query_beats[k];
                    send_beat(bt);
                    if (!(bt.nob && !bt.last)) sent++;
                end
            end
        end

        // Drain and let the pipeline settle before the verdict.
        i_s_tvalid <= 1'b0;
        while (decoded_q.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
